@@ design/u16d_pkg.sv @@
// Shared types and constants for the UTF-16 to code point decoder.
// No dependencies; used by every module of the decoder but u16d_out_stage.
package u16d_pkg;

  // default width of the byte offset counter
  localparam int unsigned OFFSET_WIDTH_DEF = 16;

  // field widths fixed by the stream format
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CP_W     = 21;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned HIGH_W   = 10;

  // special 16-bit units
  localparam logic [15:0] UNIT_BOM_BE   = 16'hFEFF;
  localparam logic [15:0] UNIT_BOM_LE   = 16'hFFFE;
  localparam logic [15:0] UNIT_HIGH_LO  = 16'hD800;
  localparam logic [15:0] UNIT_LOW_LO   = 16'hDC00;
  localparam logic [15:0] UNIT_LOW_END  = 16'hE000;
  localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_CHAR      = 3'd0,
    ST_CHAR_END  = 3'd1,
    ST_END       = 3'd2,
    ST_ILLEGAL   = 3'd3,
    ST_TRUNC     = 3'd4
  } status_t;

  // one input item
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } item_t;

endpackage

@@ design/u16d_in_stage.sv @@
// Input register of the decoder: holds one accepted byte until the decode
// stage takes it. Depends on u16d_pkg.
module u16d_in_stage
  import u16d_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  // take a new byte when empty or when the held one moves on this cycle
  assign in_ready   = !valid_r || advance;
  assign valid_nxt  = in_ready ? in_valid : valid_r;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

@@ design/u16d_decode.sv @@
// Per-byte decode: byte pairing, order marks, surrogate pairing and error
// tracking, with the message state registers. Depends on u16d_pkg.
module u16d_decode
  import u16d_pkg::*;
#(
  parameter int unsigned OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic                    cfg_wr_data,
  input  logic                    fire,
  input  item_t                   item,
  output logic                    res_valid,
  output logic [CP_W-1:0]         res_code_point,
  output status_t                 res_status,
  output logic [OFFSET_WIDTH-1:0] res_byte_offset
);

  localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = '1;

  logic                    start_le_r;
  logic                    have_first_r, have_first_nxt;
  logic [BYTE_W-1:0]       held_byte_r, held_byte_nxt;
  logic                    pending_r, pending_nxt;
  logic [HIGH_W-1:0]       high_bits_r, high_bits_nxt;
  logic                    le_r, le_nxt;
  logic                    dropping_r, dropping_nxt;
  logic [OFFSET_WIDTH-1:0] seen_r, seen_nxt;
  logic [OFFSET_WIDTH-1:0] unit_off_r, unit_off_nxt;

  logic                    le_cur;
  logic [OFFSET_WIDTH-1:0] seen_inc;
  logic [15:0]             unit;
  logic                    is_high, is_low, is_mark;
  logic                    end_msg;

  // byte order register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_le_r <= 1'b0;
    end else if (cfg_wr_en) begin
      start_le_r <= cfg_wr_data;
    end
  end

  // order reloads at the first byte of a message
  assign le_cur   = (seen_r == '0) ? start_le_r : le_r;
  assign seen_inc = (seen_r == OFFSET_MAX) ? seen_r : seen_r + 1'b1;
  assign unit     = le_cur ? {item.data_byte, held_byte_r} : {held_byte_r, item.data_byte};
  assign is_mark  = (unit == UNIT_BOM_BE) || (unit == UNIT_BOM_LE);
  assign is_high  = (unit >= UNIT_HIGH_LO) && (unit < UNIT_LOW_LO);
  assign is_low   = (unit >= UNIT_LOW_LO) && (unit < UNIT_LOW_END);

  // next state and result
  always_comb begin
    have_first_nxt  = have_first_r;
    held_byte_nxt   = held_byte_r;
    pending_nxt     = pending_r;
    high_bits_nxt   = high_bits_r;
    le_nxt          = le_r;
    dropping_nxt    = dropping_r;
    seen_nxt        = seen_r;
    unit_off_nxt    = unit_off_r;
    end_msg         = 1'b0;
    res_valid       = 1'b0;
    res_code_point  = '0;
    res_status      = ST_CHAR;
    res_byte_offset = '0;
    if (fire) begin
      if (dropping_r) begin
        end_msg = item.last_byte;
      end else begin
        le_nxt   = le_cur;
        seen_nxt = seen_inc;
        if (!have_first_r) begin
          // first byte of a unit
          if (!pending_r) begin
            unit_off_nxt = seen_r;
          end
          held_byte_nxt  = item.data_byte;
          have_first_nxt = 1'b1;
          if (item.last_byte) begin
            res_valid       = 1'b1;
            res_status      = ST_TRUNC;
            res_byte_offset = pending_r ? unit_off_r : seen_r;
            end_msg         = 1'b1;
          end
        end else begin
          have_first_nxt = 1'b0;
          if (pending_r) begin
            // second unit of a surrogate pair
            if (is_low) begin
              pending_nxt     = 1'b0;
              res_valid       = 1'b1;
              res_code_point  = SUPP_BASE + {1'b0, high_bits_r, unit[9:0]};
              res_status      = item.last_byte ? ST_CHAR_END : ST_CHAR;
              res_byte_offset = seen_inc;
            end else begin
              res_valid       = 1'b1;
              res_status      = ST_ILLEGAL;
              res_byte_offset = unit_off_r;
              dropping_nxt    = !item.last_byte;
            end
            end_msg = item.last_byte;
          end else if (is_mark) begin
            le_nxt = (unit == UNIT_BOM_LE);
            if (item.last_byte) begin
              res_valid       = 1'b1;
              res_status      = ST_END;
              res_byte_offset = seen_inc;
              end_msg         = 1'b1;
            end
          end else if (is_high) begin
            high_bits_nxt = unit[HIGH_W-1:0];
            pending_nxt   = 1'b1;
            if (item.last_byte) begin
              res_valid       = 1'b1;
              res_status      = ST_TRUNC;
              res_byte_offset = unit_off_r;
              end_msg         = 1'b1;
            end
          end else if (is_low) begin
            // lone low surrogate
            res_valid       = 1'b1;
            res_status      = ST_ILLEGAL;
            res_byte_offset = unit_off_r;
            dropping_nxt    = !item.last_byte;
            end_msg         = item.last_byte;
          end else begin
            res_valid       = 1'b1;
            res_code_point  = {{(CP_W-16){1'b0}}, unit};
            res_status      = item.last_byte ? ST_CHAR_END : ST_CHAR;
            res_byte_offset = seen_inc;
            end_msg         = item.last_byte;
          end
        end
      end
      // message end clears all message state but the byte order
      if (end_msg) begin
        have_first_nxt = 1'b0;
        held_byte_nxt  = '0;
        pending_nxt    = 1'b0;
        high_bits_nxt  = '0;
        dropping_nxt   = 1'b0;
        seen_nxt       = '0;
        unit_off_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_first_r <= 1'b0;
      held_byte_r  <= '0;
      pending_r    <= 1'b0;
      high_bits_r  <= '0;
      le_r         <= 1'b0;
      dropping_r   <= 1'b0;
      seen_r       <= '0;
      unit_off_r   <= '0;
    end else begin
      have_first_r <= have_first_nxt;
      held_byte_r  <= held_byte_nxt;
      pending_r    <= pending_nxt;
      high_bits_r  <= high_bits_nxt;
      le_r         <= le_nxt;
      dropping_r   <= dropping_nxt;
      seen_r       <= seen_nxt;
      unit_off_r   <= unit_off_nxt;
    end
  end

endmodule

@@ design/u16d_out_stage.sv @@
// Result register of the decoder: holds one result until the sink takes it.
// Depends on u16d_pkg only through the modules around it.
module u16d_out_stage #(
  parameter int unsigned DATA_W = 40
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic [DATA_W-1:0] load_data,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);

  logic              valid_r, valid_nxt;
  logic [DATA_W-1:0] data_r;

  // room when empty or when the held result leaves this cycle
  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

@@ design/utf16_to_codepoint_decoder.sv @@
// Decodes a UTF-16 byte stream into Unicode code points at one byte per clock
// cycle while out_tready does not stall the result register; each byte passes
// the input register, then decode logic into the result register. Bytes pair
// into units in the current byte order; the order starts from cfg_wr_data's
// register at each message, and FEFF/FFFE marks switch it and yield nothing.
// Surrogate pairs combine into one code point. A message ends with a result
// carrying status 1 or 2 on a good end, 3 on an illegal sequence (rest of the
// message dropped) or 4 on a truncated unit or pair; byte offsets saturate at
// the counter width. Write the order register only while the block is idle.
//
// Holds the top level; depends on u16d_pkg, u16d_in_stage, u16d_decode and
// u16d_out_stage.
module utf16_to_codepoint_decoder
  import u16d_pkg::*;
#(
  parameter int unsigned OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // configuration
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,   // start_little_endian
  // byte input
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [BYTE_W-1:0]   in_tdata,    // data_byte
  input  logic                in_tlast,    // last_byte
  // result output
  output logic                out_tvalid,
  input  logic                out_tready,
  // code_point [20:0], status [23:21], byte_offset [OFFSET_WIDTH+23:24], zero pad
  output logic [((CP_W+STATUS_W+OFFSET_WIDTH+7)/8)*8-1:0] out_tdata
);

  localparam int unsigned RES_W = CP_W + STATUS_W + OFFSET_WIDTH;
  localparam int unsigned OUT_W = ((RES_W + 7) / 8) * 8;

  item_t                   in_item, item;
  logic                    item_valid;
  logic                    can_load;
  logic                    fire;
  logic                    res_valid;
  logic [CP_W-1:0]         res_code_point;
  status_t                 res_status;
  logic [OFFSET_WIDTH-1:0] res_byte_offset;
  logic [OUT_W-1:0]        res_data;

  assign in_item.data_byte = in_tdata;
  assign in_item.last_byte = in_tlast;

  u16d_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (can_load),
    .item_valid (item_valid),
    .item       (item)
  );

  // a held byte is decoded when the result register has room
  assign fire = item_valid && can_load;

  u16d_decode #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_dec (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .fire            (fire),
    .item            (item),
    .res_valid       (res_valid),
    .res_code_point  (res_code_point),
    .res_status      (res_status),
    .res_byte_offset (res_byte_offset)
  );

  // pack result fields, lowest first, zero padded to whole bytes
  assign res_data = OUT_W'({res_byte_offset, res_status, res_code_point});

  u16d_out_stage #(
    .DATA_W (OUT_W)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire && res_valid),
    .load_data (res_data),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule
